>>> design/xoshiro256plus_with_jump_schedule_assert.svh
// assertion macros used by the port-level checker
`ifndef XOSHIRO256PLUS_WITH_JUMP_SCHEDULE_ASSERT_SVH
`define XOSHIRO256PLUS_WITH_JUMP_SCHEDULE_ASSERT_SVH

// antecedent in this cycle, consequent in the next
`define XJS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

// antecedent and consequent in the same cycle
`define XJS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/xjs_pkg.sv
// types, constants and the generator step for the xoshiro256+ block
package xjs_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned MaskW = 256;
	localparam int unsigned BitIdxW = 8;

	localparam logic [WordW-1:0] SEED_XOR_A = 64'hdeadbeefdeadbeef;
	localparam logic [WordW-1:0] SEED_XOR_B = 64'hfeedbeeffeedbeef;

	// word 0 in the low bits, bit index = word * 64 + bit
	localparam logic [MaskW-1:0] SHORT_MASK = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};
	localparam logic [MaskW-1:0] LONG_MASK = {
		64'h39109bb02acbe635, 64'h77710069854ee241,
		64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
	};

	localparam logic OP_RESEED = 1'b0;
	localparam logic OP_DRAW   = 1'b1;

	localparam logic [2:0] COUNT_LAST = 3'd5;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [3:0] gen_state_t;

	typedef struct packed {
		logic load;    // load state from seed
		logic adv;     // one generator step
		logic acc_clr; // clear jump accumulator
		logic acc_en;  // fold current state into accumulator
		logic commit;  // state takes accumulator result
	} step_ctrl_t;

	function automatic gen_state_t gen_advance(input gen_state_t s);
		word_t t2;
		word_t t3;
		gen_state_t n;
		t2 = s[2] ^ s[0];
		t3 = s[3] ^ s[1];
		n[0] = s[0] ^ t3;
		n[1] = s[1] ^ t2;
		n[2] = t2 ^ {s[1][WordW-18:0], 17'd0};
		n[3] = {t3[18:0], t3[WordW-1:19]};
		return n;
	endfunction

endpackage

>>> design/xjs_if.sv
// request and response channel interfaces
interface xjs_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [63:0] seed;

	modport source (output valid, output op, output seed, input ready);
	modport sink (input valid, input op, input seed, output ready);
endinterface

interface xjs_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

>>> design/xjs_step_unit.sv
// generator state, jump accumulator and the shared step logic
module xjs_step_unit
	import xjs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_ctrl_t ctrl,
	input  word_t      seed,
	output word_t      sum
);

	gen_state_t state_q;
	gen_state_t acc_q;
	gen_state_t acc_next;
	gen_state_t state_adv;

	assign state_adv = gen_advance(state_q);
	assign sum       = state_q[0] + state_q[3];

	always_comb begin
		acc_next = acc_q;
		if (ctrl.acc_en) begin
			acc_next = acc_q ^ state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctrl.load) begin
			state_q[0] <= seed;
			state_q[1] <= seed ^ SEED_XOR_A;
			state_q[2] <= ~seed;
			state_q[3] <= seed ^ SEED_XOR_B;
		end else if (ctrl.commit) begin
			state_q <= acc_next;
		end else if (ctrl.adv) begin
			state_q <= state_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_next;
		end
	end

endmodule

>>> design/xjs_seq.sv
// sequencer: draw counter, jump schedule and step control
module xjs_seq
	import xjs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_op,
	output logic       req_ready,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       out_free,
	output logic       out_load,
	output step_ctrl_t ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_JUMP = 3'b010,
		ST_DRAW = 3'b100
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic               sched_on_q;
	logic [2:0]         count_q;
	logic [2:0]         count_d;
	logic [2:0]         count_inc;
	logic [BitIdxW-1:0] bit_idx_q;
	logic               long_q;
	logic               long_d;
	logic               req_acc;
	logic               want_long;
	logic               want_short;
	logic               mask_bit;

	assign req_ready  = (state_q == ST_IDLE);
	assign req_acc    = req_valid && req_ready;
	assign count_inc  = (count_q == COUNT_LAST) ? 3'd0 : count_q + 3'd1;
	assign want_long  = (count_inc == 3'd0) || (count_inc == 3'd3);
	assign want_short = (count_inc == 3'd2) || (count_inc == 3'd4);
	assign mask_bit   = long_q ? LONG_MASK[bit_idx_q] : SHORT_MASK[bit_idx_q];

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		long_d   = long_q;
		ctrl     = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if (req_op == OP_RESEED) begin
						ctrl.load = 1'b1;
						count_d   = 3'd0;
					end else begin
						count_d = count_inc;
						if (sched_on_q && (want_long || want_short)) begin
							long_d       = want_long;
							ctrl.acc_clr = 1'b1;
							state_d      = ST_JUMP;
						end else begin
							state_d = ST_DRAW;
						end
					end
				end
			end
			ST_JUMP: begin
				ctrl.adv    = 1'b1;
				ctrl.acc_en = mask_bit;
				if (bit_idx_q == '1) begin
					ctrl.commit = 1'b1;
					state_d     = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (out_free) begin
					ctrl.adv = 1'b1;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= 3'd0;
			long_q     <= 1'b0;
			bit_idx_q  <= '0;
			sched_on_q <= 1'b1;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			long_q  <= long_d;
			if (state_q == ST_JUMP) begin
				bit_idx_q <= bit_idx_q + 1'b1;
			end else begin
				bit_idx_q <= '0;
			end
			if (cfg_we) begin
				sched_on_q <= cfg_wdata;
			end
		end
	end

endmodule

>>> design/xoshiro256plus_with_jump_schedule.sv
// top level of the xoshiro256+ generator with jump schedule
//
//   channel  dir  payload               handshake
//   req      in   op[0], seed[63:0]     valid/ready
//   rsp      out  value[63:0]           valid/ready
//   cfg      in   cfg_wdata[0]          cfg_we, no wait
//
// reseed is done in its accept cycle; a plain draw passes through accept and draw
// a draw that jumps runs 256 jump steps through the one step unit between accept and draw
// reset: state words zero, draw counter 0, jump schedule on
// the result register holds a response until taken; a draw that is ready to
// return waits in its draw cycle while the result register is still full
module xoshiro256plus_with_jump_schedule
	import xjs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	xjs_req_if.sink   req,
	xjs_rsp_if.source rsp,
	input  logic   cfg_we,
	input  logic   cfg_wdata
);

	step_ctrl_t ctrl;
	word_t      sum;
	word_t      value_q;
	logic       valid_q;
	logic       out_load;
	logic       out_free;

	assign out_free  = !valid_q || rsp.ready;
	assign rsp.valid = valid_q;
	assign rsp.value = value_q;

	xjs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.out_load  (out_load),
		.ctrl      (ctrl)
	);

	xjs_step_unit u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.seed   (req.seed),
		.sum    (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= sum;
		end
	end

endmodule

>>> design/xjs_checker.sv
// port-level checker for the generator and its bind
`include "xoshiro256plus_with_jump_schedule_assert.svh"

module xjs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_op,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_value
);

	// a stalled response holds
	`XJS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "response dropped or changed while stalled")

	// after a draw request the block is busy in the next cycle
	`XJS_ASSERT_NEXT(a_draw_busy, clk, arst_n, req_valid && req_ready && req_op, !req_ready, "ready after draw request")

	// after a reseed the block is ready again in the next cycle
	`XJS_ASSERT_NEXT(a_reseed_fast, clk, arst_n, req_valid && req_ready && !req_op, req_ready, "not ready after reseed")

	// a new response only comes out of a busy cycle
	`XJS_ASSERT_SAME(a_rsp_from_draw, clk, arst_n, $rose(rsp_valid), $past(!req_ready), "response without draw")

endmodule

bind xoshiro256plus_with_jump_schedule xjs_checker u_xjs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_op    (req.op),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);

>>> verif/xjs_value_checker.sv
// watches the request, response and config ports, predicts each drawn value and compares
module xjs_value_checker
	import xjs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	xjs_req_if   req,
	xjs_rsp_if   rsp,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   fail_count,
	output int   expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	gen_state_t  words;
	logic [2:0]  draws_mod6;
	logic        jumps_on;
	word_t       value_queue[$];

	// returns s0 + s3, then steps the four words once
	function automatic word_t advance_words();
		word_t sum;
		word_t shifted;
		sum = words[0] + words[3];
		shifted = words[1] << 17;
		words[2] = words[2] ^ words[0];
		words[3] = words[3] ^ words[1];
		words[1] = words[1] ^ words[2];
		words[0] = words[0] ^ words[3];
		words[2] = words[2] ^ shifted;
		words[3] = (words[3] << 45) | (words[3] >> 19);
		return sum;
	endfunction

	// 256 steps, folding the state into the result wherever the mask bit is set
	function automatic void jump_ahead(input logic [MaskW-1:0] mask);
		gen_state_t acc;
		acc = '0;
		for (int i = 0; i < MaskW; i++) begin
			if (mask[i])
				acc = acc ^ words;
			void'(advance_words());
		end
		words = acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			words = '0;
			draws_mod6 = 3'd0;
			jumps_on = 1'b1;
			value_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_we === 1'b1)
				jumps_on = cfg_wdata;
			// pop before push: a response never belongs to a request taken on the same edge
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (value_queue.size() == 0) begin
					$display("%0t: unexpected value: expected none, actual %h", $time, rsp.value);
					fail_count++;
				end else begin
					want = value_queue.pop_front();
					if (rsp.value !== want) begin
						$display("%0t: value mismatch: expected %h, actual %h",
							$time, want, rsp.value);
						fail_count++;
					end
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				if (req.op == OP_RESEED) begin
					words[0] = req.seed;
					words[1] = req.seed ^ SEED_XOR_A;
					words[2] = ~req.seed;
					words[3] = req.seed ^ SEED_XOR_B;
					draws_mod6 = 3'd0;
				end else begin
					draws_mod6 = (draws_mod6 == COUNT_LAST) ? 3'd0 : 3'(draws_mod6 + 3'd1);
					if (jumps_on) begin
						if (draws_mod6 % 3 == 0)
							jump_ahead(LONG_MASK);
						else if (draws_mod6[0] == 1'b0)
							jump_ahead(SHORT_MASK);
					end
					value_queue.push_back(advance_words());
				end
			end
		end
		expected_left = value_queue.size();
	end

endmodule

>>> verif/xoshiro256plus_with_jump_schedule_test.sv
// testbench top: clock, reset, request and config stimulus, response stalls and the verdict
module xoshiro256plus_with_jump_schedule_test
	import xjs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_REQUESTS = 110;
	localparam int PHASE_COUNT = 5;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   expected_left;
	int   cycle_count;
	bit   no_idle;

	xjs_req_if req_ch ();
	xjs_rsp_if rsp_ch ();

	xoshiro256plus_with_jump_schedule u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	xjs_value_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.expected_left(expected_left)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("xoshiro256plus_with_jump_schedule regression: fail");
			$finish;
		end
	end

	// response side stalls in short bursts
	initial begin
		int  stall_left;
		logic take;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (no_idle) begin
				take = 1'b1;
			end else if (stall_left > 0) begin
				take = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				take = 1'b0;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				take = 1'b1;
			end
			rsp_ch.ready <= take;
		end
	end

	// starts and ends on a falling edge with no pending assignment to valid
	task automatic send_request(input logic op, input word_t seed);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.seed <= seed;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// a reseed returns nothing, so let the block settle for SETTLE_CYCLES once the queue drains
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_schedule(input logic on);
		cfg_we <= 1'b1;
		cfg_wdata <= on;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic word_t pick_seed();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, WordW - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_DRAW;
		req_ch.seed = '0;
		no_idle = 1'b0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// draws on the all-zero state stay zero through plain, jump and long-jump draws
		repeat (3) send_request(OP_DRAW, '1);
		// a full counter cycle from a zero seed
		send_request(OP_RESEED, '0);
		repeat (6) send_request(OP_DRAW, '0);
		send_request(OP_RESEED, '1);
		repeat (2) send_request(OP_DRAW, 64'h0123_4567_89ab_cdef);
		send_request(OP_RESEED, 64'h8000_0000_0000_0001);
		send_request(OP_DRAW, '0);
		send_request(OP_RESEED, 64'h5555_5555_5555_5555);
		send_request(OP_DRAW, '1);
		// reseed in the middle of a count clears it
		send_request(OP_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
		repeat (3) send_request(OP_DRAW, '0);

		drain_requests();
		write_schedule(1'b0);
		send_request(OP_RESEED, SEED_XOR_A);
		repeat (3) send_request(OP_DRAW, '1);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			drain_requests();
			write_schedule(phase[0] ? 1'b0 : 1'b1);
			if (phase == PHASE_COUNT - 1)
				no_idle = 1'b1;
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_request(OP_RESEED, pick_seed());
				else
					send_request(OP_DRAW, pick_seed());
			end
		end

		drain_requests();
		if (fail_count == 0)
			$display("xoshiro256plus_with_jump_schedule regression: pass");
		else
			$display("xoshiro256plus_with_jump_schedule regression: fail");
		$finish;
	end

endmodule
